// ===== src/fbpa_pkg.sv =====
// shared types and constants for the fixed block pool allocator
package fbpa_pkg;

    localparam int CNT_W   = 7;
    localparam int IDX_W_IN = 6;
    localparam int BYTES_W = 16;
    localparam int OFF_W   = 22;
    localparam int PROD_W  = CNT_W + BYTES_W;
    localparam int CHUNK   = 8;
    localparam int CHUNK_W = 3;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic CFG_BLOCK_COUNT = 1'b0;
    localparam logic CFG_BLOCK_BYTES = 1'b1;

    localparam logic [CNT_W-1:0]   COUNT_RST = 7'd64;
    localparam logic [BYTES_W-1:0] BYTES_RST = 16'd64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_BUSY  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic scan;
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic is_release;
        logic scan_done;
    } t_dp_stat;

endpackage

// ===== src/fixed_block_pool_allocator.sv =====
// fixed block pool allocator top level
// A command is taken when start is high and busy is low; its result appears
// for one cycle with o_result_valid and cannot be held off. A release passes
// through the scan state without scanning; an acquire examines the 8-block
// words of the busy map in turn with the first-free scan until a free block
// is found, at most ceil(min(MAX_BLOCKS,127)/8) words. Configuration writes
// are registered and should be made while busy is low.
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [IDX_W_IN-1:0] i_block_index,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [BYTES_W-1:0]  i_cfg_data,
    output logic                o_result_valid,
    output logic [1:0]          o_status,
    output logic [IDX_W_IN-1:0] o_granted_index,
    output logic [OFF_W-1:0]    o_granted_offset,
    output logic [CNT_W-1:0]    o_used_count,
    output logic [CNT_W-1:0]    o_peak_count
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    fbpa_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_stat         (dp_stat),
        .o_cmd          (dp_cmd),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_ctl        (dp_cmd),
        .o_stat           (dp_stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (i_cmd),
        .i_block_index    (i_block_index),
        .o_status         (o_status),
        .o_granted_index  (o_granted_index),
        .o_granted_offset (o_granted_offset),
        .o_used_count     (o_used_count),
        .o_peak_count     (o_peak_count)
    );

endmodule

// ===== src/fbpa_ctrl.sv =====
// controller state machine for the fixed block pool allocator
module fbpa_ctrl
    import fbpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_result_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.is_release || i_stat.scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_busy         = 1'b1;
        o_result_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_SCAN: begin
                o_cmd.scan = !i_stat.is_release;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_OUT: begin
                o_result_valid = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/fbpa_datapath.sv =====
// busy map, counters, configuration and offset math for the block pool
module fbpa_datapath
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd_ctl,
    output t_dp_stat            o_stat,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [BYTES_W-1:0]  i_cfg_data,
    input  logic                i_cmd,
    input  logic [IDX_W_IN-1:0] i_block_index,
    output logic [1:0]          o_status,
    output logic [IDX_W_IN-1:0] o_granted_index,
    output logic [OFF_W-1:0]    o_granted_offset,
    output logic [CNT_W-1:0]    o_used_count,
    output logic [CNT_W-1:0]    o_peak_count
);

    // indices never reach 127, so the map need not be wider
    localparam int MAP_DEPTH = (MAX_BLOCKS < 127) ? MAX_BLOCKS : 127;
    localparam int IDX_W     = $clog2(MAP_DEPTH);
    localparam int NWORDS    = (MAP_DEPTH + CHUNK - 1) / CHUNK;
    localparam int WORD_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int POS_W     = WORD_W + CHUNK_W;
    localparam int CMP_W     = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam logic [CNT_W-1:0]  CAP       = CNT_W'(MAP_DEPTH);
    localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(NWORDS - 1);

    logic [MAP_DEPTH-1:0] r_map;
    logic [CNT_W-1:0]     r_total;
    logic [CNT_W-1:0]     r_peak;
    logic [CNT_W-1:0]     r_count;
    logic [BYTES_W-1:0]   r_bytes;
    logic                 r_cmd;
    logic [IDX_W_IN-1:0]  r_idx;
    logic [WORD_W-1:0]    r_word;
    logic                 r_found;
    logic [CNT_W-1:0]     r_hit_idx;
    t_status              r_status;
    logic [IDX_W_IN-1:0]  r_gidx;
    logic [PROD_W-1:0]    r_prod;

    logic [CNT_W-1:0] limit;
    logic             hit;
    logic [POS_W-1:0] hit_pos;
    logic [CMP_W-1:0] idx_ext;
    logic [CNT_W-1:0] total_inc;

    assign limit     = (r_count > CAP) ? CAP : r_count;
    assign idx_ext   = CMP_W'(r_idx);
    assign total_inc = r_total + CNT_W'(1);

    // first free block within the current word of the map
    always_comb begin
        logic [POS_W-1:0] pos;
        hit     = 1'b0;
        hit_pos = '0;
        for (int k = CHUNK - 1; k >= 0; k--) begin
            pos = {r_word, CHUNK_W'(k)};
            if ((CMP_W'(pos) < CMP_W'(limit)) && !r_map[pos[IDX_W-1:0]]) begin
                hit     = 1'b1;
                hit_pos = pos;
            end
        end
    end

    assign o_stat.is_release = (r_cmd == CMD_RELEASE);
    assign o_stat.scan_done  = hit || (r_word == LAST_WORD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RST;
            r_bytes <= BYTES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BLOCK_COUNT: r_count <= i_cfg_data[CNT_W-1:0];
                CFG_BLOCK_BYTES: r_bytes <= i_cfg_data;
                default:         r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_total <= '0;
            r_peak  <= '0;
        end else if (i_cmd_ctl.exec) begin
            if (r_cmd == CMD_ACQUIRE) begin
                if (r_found) begin
                    r_map[r_hit_idx[IDX_W-1:0]] <= 1'b1;
                    r_total                     <= total_inc;
                    if (total_inc > r_peak) begin
                        r_peak <= total_inc;
                    end
                end
            end else if ((idx_ext < CMP_W'(limit)) && r_map[idx_ext[IDX_W-1:0]]) begin
                r_map[idx_ext[IDX_W-1:0]] <= 1'b0;
                r_total                   <= r_total - CNT_W'(1);
            end
        end
    end

    // transaction payload, scan progress and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load) begin
            r_cmd     <= i_cmd;
            r_idx     <= i_block_index;
            r_word    <= '0;
            r_found   <= 1'b0;
            r_hit_idx <= '0;
        end else if (i_cmd_ctl.scan) begin
            if (hit) begin
                r_found   <= 1'b1;
                r_hit_idx <= CNT_W'(hit_pos);
            end else if (r_word != LAST_WORD) begin
                r_word <= r_word + WORD_W'(1);
            end
        end
        if (i_cmd_ctl.exec) begin
            if ((r_cmd == CMD_ACQUIRE) && r_found) begin
                r_status <= ST_OK;
                r_gidx   <= r_hit_idx[IDX_W_IN-1:0];
                r_prod   <= PROD_W'(r_hit_idx) * PROD_W'(r_bytes);
            end else begin
                r_gidx <= '0;
                r_prod <= '0;
                if (r_cmd == CMD_ACQUIRE) begin
                    r_status <= ST_EXHAUSTED;
                end else if (idx_ext >= CMP_W'(limit)) begin
                    r_status <= ST_RANGE;
                end else if (!r_map[idx_ext[IDX_W-1:0]]) begin
                    r_status <= ST_NOT_BUSY;
                end else begin
                    r_status <= ST_OK;
                end
            end
        end
    end

    assign o_status         = r_status;
    assign o_granted_index  = r_gidx;
    assign o_granted_offset = r_prod[OFF_W-1:0];
    assign o_used_count     = r_total;
    assign o_peak_count     = r_peak;

endmodule

// ===== src/fbpa_checker.sv =====
// port level checks for the fixed block pool allocator and their binding
module fbpa_assertions
    import fbpa_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_result_valid,
    input logic [1:0]          o_status,
    input logic [IDX_W_IN-1:0] o_granted_index,
    input logic [OFF_W-1:0]    o_granted_offset,
    input logic [CNT_W-1:0]    o_used_count,
    input logic [CNT_W-1:0]    o_peak_count
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_result_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy ##1 !busy)
        else $error("result strobe outside a transaction");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status != ST_OK) |->
            (o_granted_index == '0) && (o_granted_offset == '0))
        else $error("failed transaction carries a grant");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_used_count <= o_peak_count))
        else $error("used count above peak");

endmodule

bind fixed_block_pool_allocator fbpa_assertions u_fbpa_assertions (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_result_valid   (o_result_valid),
    .o_status         (o_status),
    .o_granted_index  (o_granted_index),
    .o_granted_offset (o_granted_offset),
    .o_used_count     (o_used_count),
    .o_peak_count     (o_peak_count)
);
